// ===== rtl/look_at_view_matrix_assert.svh =====
// assertion macros shared by the look-at view matrix rtl
// no dependencies; taken in by the files that check their own logic
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// same-cycle implication
`define LAV_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("look_at_view_matrix: same-cycle check failed");

// next-cycle implication
`define LAV_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("look_at_view_matrix: next-cycle check failed");

`endif

// ===== rtl/lav_pkg.sv =====
// types, constants and rounding helper for the look-at view matrix
// no dependencies; used by the front end, normaliser, back end and top level
`default_nettype none

package lav_pkg;

  // default depth of the queue between front and back (power of two)
  localparam int QDEPTH = 4;

  // width of a unit vector component, range -65536..65536
  localparam int UNIT_W = 18;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] camera_up_x;
    logic signed [31:0] camera_up_y;
    logic signed [31:0] camera_up_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } out_word_t;

  // queued job: view direction plus the vectors the back end still needs
  typedef struct packed {
    logic [2:0][32:0] dir;
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
  } task_t;

  // q32.32 to q16.16, half away from zero, saturated to 32 bits
  function automatic logic [31:0] round_sat(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [47:0] q;
    logic [47:0] nq;
    mag = v[63] ? 64'(-v) : 64'(v);
    q = 48'((mag + 64'h8000) >> 16);
    if (v[63]) begin
      if (q > 48'h0000_8000_0000) begin
        q = 48'h0000_8000_0000;
      end
      nq = -q;
      return nq[31:0];
    end
    if (q > 48'h0000_7FFF_FFFF) begin
      q = 48'h0000_7FFF_FFFF;
    end
    return q[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lav_chan_if.sv =====
// valid/ready channel carrying one word of a packed payload type
// payload types come from lav_pkg
`default_nettype none

interface lav_chan_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lav_queue.sv =====
// short register queue between the front and back ends
// depends on the assertion macro header
`default_nettype none
`include "look_at_view_matrix_assert.svh"

module lav_queue #(
  parameter int DEPTH = 4,
  parameter int W     = 288
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      head,
  output logic              not_empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  slot_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rp_r];

  // pointers wrap naturally, depth is a power of two
  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  `LAV_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `LAV_ASSERT_NEXT(a_q_drain, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 1'b1)
  `LAV_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(DEPTH))

endmodule

`default_nettype wire

// ===== rtl/lav_front.sv =====
// front end: takes the input word, forms the view direction, queues the job
// depends on lav_pkg and lav_chan_if
`default_nettype none

module lav_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lav_chan_if.sink        in_word,
  input  wire logic       q_full,
  output logic            q_push,
  output lav_pkg::task_t  q_data
);

  lav_pkg::in_word_t item_r;
  logic              fv_r;
  logic              take;

  assign take          = in_word.valid && in_word.ready;
  assign q_push        = fv_r && !q_full;
  assign in_word.ready = !fv_r || !q_full;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (take) begin
      fv_r <= 1'b1;
    end else if (q_push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_word.data;
    end
  end

  // direction target minus eye, 33 bits so it never wraps
  always_comb begin
    q_data.dir[0] = 33'(item_r.target_x) - 33'(item_r.eye_x);
    q_data.dir[1] = 33'(item_r.target_y) - 33'(item_r.eye_y);
    q_data.dir[2] = 33'(item_r.target_z) - 33'(item_r.eye_z);
    q_data.eye[0] = item_r.eye_x;
    q_data.eye[1] = item_r.eye_y;
    q_data.eye[2] = item_r.eye_z;
    q_data.up[0]  = item_r.upward_x;
    q_data.up[1]  = item_r.upward_y;
    q_data.up[2]  = item_r.upward_z;
  end

endmodule

`default_nettype wire

// ===== rtl/lav_norm.sv =====
// pipelined vector normaliser: scale, sum of squares, bit-serial root, divide
// depends on lav_pkg; carries a sideband word alongside the vector
`default_nettype none

module lav_norm #(
  parameter int IW = 33,
  parameter int SW = 192
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_vld,
  input  wire logic [2:0][IW-1:0]               in_vec,
  input  wire logic [SW-1:0]                    in_sb,
  output logic                                  out_vld,
  output logic [2:0][lav_pkg::UNIT_W-1:0]       out_vec,
  output logic [SW-1:0]                         out_sb
);

  localparam int SQ_N = 32;
  localparam int DV_N = 17;
  localparam int LAT  = 6 + SQ_N + 1 + DV_N + 1;
  localparam int XW   = SW + 4;
  localparam int PW   = $clog2(IW);
  localparam int UW   = lav_pkg::UNIT_W;

  // valid and sideband delay line
  logic [LAT-1:0] vld_r;
  logic [XW-1:0]  xsb_r [LAT];
  logic [2:0]     sgn;
  logic           zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn[i] = in_vec[i][IW-1];
    end
    zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xsb_r[0] <= {zero, sgn, in_sb};
      for (int i = 1; i < LAT; i++) begin
        xsb_r[i] <= xsb_r[i-1];
      end
    end
  end

  // magnitudes
  logic [2:0][IW-1:0] mag_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= sgn[i] ? -in_vec[i] : in_vec[i];
      end
    end
  end

  // largest magnitude
  logic [2:0][IW-1:0] a1_r;
  logic [IW-1:0]      max_r;
  logic [IW-1:0]      max01;
  assign max01 = (mag_r[1] > mag_r[0]) ? mag_r[1] : mag_r[0];
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= mag_r;
      max_r <= (mag_r[2] > max01) ? mag_r[2] : max01;
    end
  end

  // leading one of the largest magnitude gives the scaling shift
  logic [PW-1:0]      msb;
  logic [2:0][IW-1:0] a2_r;
  logic               rsh_r;
  logic [PW-1:0]      amt_r;
  always_comb begin
    msb = '0;
    for (int i = 0; i < IW; i++) begin
      if (max_r[i]) begin
        msb = PW'(i);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= a1_r;
      rsh_r <= (msb > PW'(30));
      amt_r <= (msb > PW'(30)) ? msb - PW'(30) : PW'(30) - msb;
    end
  end

  // scale so the largest lies in [2^30, 2^31), right shifts truncate
  logic [2:0][30:0] a3_r;
  logic [IW+30:0]   wide [3];
  logic [IW+30:0]   shd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {31'b0, a2_r[i]};
      shd[i]  = rsh_r ? (wide[i] >> amt_r) : (wide[i] << amt_r);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a3_r[i] <= shd[i][30:0];
      end
    end
  end

  // squares
  logic [2:0][30:0] a4_r;
  logic [61:0]      sq_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      a4_r <= a3_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 62'(a3_r[i]) * 62'(a3_r[i]);
      end
    end
  end

  // square root, one result bit per stage; index 0 holds the sum of squares
  logic [63:0]      sn_r [SQ_N+1];
  logic [63:0]      sr_r [SQ_N+1];
  logic [2:0][30:0] sa_r [SQ_N+1];
  logic [63:0]      sq_try [SQ_N];
  logic [63:0]      sq_bit [SQ_N];

  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_bit[k] = 64'd1 << (62 - 2 * k);
      sq_try[k] = sr_r[k] + sq_bit[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      sr_r[0] <= '0;
      sa_r[0] <= a4_r;
      for (int k = 0; k < SQ_N; k++) begin
        sa_r[k+1] <= sa_r[k];
        if (sn_r[k] >= sq_try[k]) begin
          sn_r[k+1] <= sn_r[k] - sq_try[k];
          sr_r[k+1] <= (sr_r[k] >> 1) + sq_bit[k];
        end else begin
          sn_r[k+1] <= sn_r[k];
          sr_r[k+1] <= sr_r[k] >> 1;
        end
      end
    end
  end

  // rounded quotient a*65536 + r/2 over r, one quotient bit per stage
  logic [2:0][47:0] dr_r [DV_N+1];
  logic [2:0][16:0] dq_r [DV_N+1];
  logic [31:0]      dd_r [DV_N+1];
  logic [31:0]      root;
  logic [48:0]      dv_try [DV_N];

  assign root = sr_r[SQ_N][31:0];

  always_comb begin
    for (int k = 0; k < DV_N; k++) begin
      dv_try[k] = 49'(dd_r[k]) << (DV_N - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= root;
      dq_r[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        dr_r[0][i] <= {1'b0, sa_r[SQ_N][i], 16'b0} + 48'(root >> 1);
      end
      for (int k = 0; k < DV_N; k++) begin
        dd_r[k+1] <= dd_r[k];
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, dr_r[k][i]} >= dv_try[k]) begin
            dr_r[k+1][i] <= dr_r[k][i] - dv_try[k][47:0];
            dq_r[k+1][i] <= dq_r[k][i] | (17'd1 << (DV_N - 1 - k));
          end else begin
            dr_r[k+1][i] <= dr_r[k][i];
            dq_r[k+1][i] <= dq_r[k][i];
          end
        end
      end
    end
  end

  // sign restore, zero vector stays zero
  logic [2:0][UW-1:0] ov_r;
  logic               z_d;
  logic [2:0]         s_d;
  assign z_d = xsb_r[LAT-2][SW+3];
  assign s_d = xsb_r[LAT-2][SW+2:SW];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (z_d) begin
          ov_r[i] <= '0;
        end else if (s_d[i]) begin
          ov_r[i] <= -UW'(dq_r[DV_N][i]);
        end else begin
          ov_r[i] <= UW'(dq_r[DV_N][i]);
        end
      end
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_vec = ov_r;
  assign out_sb  = xsb_r[LAT-1][SW-1:0];

endmodule

`default_nettype wire

// ===== rtl/lav_back.sv =====
// back end: forward and side normalisers, cross and dot products, output word
// depends on lav_pkg, lav_chan_if, lav_norm and the assertion macro header
`default_nettype none
`include "look_at_view_matrix_assert.svh"

module lav_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_vld,
  input  wire lav_pkg::task_t   q_head,
  output logic                  q_pop,
  lav_chan_if.source            out_word
);

  localparam int UW = lav_pkg::UNIT_W;
  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};

  logic en;
  logic out_vld_r;
  lav_pkg::out_word_t out_r;

  // whole pipeline moves unless a finished word is stuck at the output
  assign en    = !out_vld_r || out_word.ready;
  assign q_pop = en && q_vld;

  // forward vector
  logic                 n1_vld;
  logic [2:0][UW-1:0]   n1_vec;
  logic [191:0]         n1_sb;
  logic [2:0][31:0]     eye1, up1;

  lav_norm #(.IW(33), .SW(192)) u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (q_vld),
    .in_vec  (q_head.dir),
    .in_sb   ({q_head.eye, q_head.up}),
    .out_vld (n1_vld),
    .out_vec (n1_vec),
    .out_sb  (n1_sb)
  );

  assign eye1 = n1_sb[191:96];
  assign up1  = n1_sb[95:0];

  // cross of forward and up: products, then differences
  logic signed [49:0] pa_r [3];
  logic signed [49:0] pb_r [3];
  logic [2:0][UW-1:0] c1_f_r, c2_f_r;
  logic [2:0][31:0]   c1_e_r, c2_e_r;
  logic [2:0][50:0]   c_r;
  logic               c1_vld_r, c2_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= 50'($signed(n1_vec[NX[i]])) * 50'($signed(up1[NY[i]]));
        pb_r[i] <= 50'($signed(n1_vec[NY[i]])) * 50'($signed(up1[NX[i]]));
        c_r[i]  <= 51'(pa_r[i]) - 51'(pb_r[i]);
      end
      c1_f_r <= n1_vec;
      c1_e_r <= eye1;
      c2_f_r <= c1_f_r;
      c2_e_r <= c1_e_r;
    end
  end

  // side vector
  logic               n2_vld;
  logic [2:0][UW-1:0] n2_vec;
  logic [149:0]       n2_sb;
  logic [2:0][31:0]   eye2;
  logic [2:0][UW-1:0] f2;

  lav_norm #(.IW(51), .SW(150)) u_norm_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (c2_vld_r),
    .in_vec  (c_r),
    .in_sb   ({c2_e_r, c2_f_r}),
    .out_vld (n2_vld),
    .out_vec (n2_vec),
    .out_sb  (n2_sb)
  );

  assign eye2 = n2_sb[149:54];
  assign f2   = n2_sb[53:0];

  // camera up and the side and forward dot products
  logic signed [35:0] ua_r [3];
  logic signed [35:0] ub_r [3];
  logic signed [49:0] ps_r [3];
  logic signed [49:0] pf_r [3];
  logic signed [36:0] cc [3];
  logic [2:0][31:0]   u_r, u3_r, u4_r;
  logic signed [51:0] dot_s_r, dot_f_r;
  logic signed [50:0] pu_r [3];
  logic signed [52:0] dot_u_r;
  logic [31:0]        shx_r, shz_r, shx4_r, shz4_r;
  logic [2:0][UW-1:0] d1_s_r, d2_s_r, d3_s_r, d4_s_r;
  logic [2:0][UW-1:0] d1_f_r, d2_f_r, d3_f_r, d4_f_r;
  logic [2:0][31:0]   d1_e_r, d2_e_r;
  logic               d1_vld_r, d2_vld_r, d3_vld_r, d4_vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cc[i] = 37'(ua_r[i]) - 37'(ub_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ua_r[i] <= 36'($signed(n2_vec[NX[i]])) * 36'($signed(f2[NY[i]]));
        ub_r[i] <= 36'($signed(n2_vec[NY[i]])) * 36'($signed(f2[NX[i]]));
        ps_r[i] <= 50'($signed(n2_vec[i])) * 50'($signed(eye2[i]));
        pf_r[i] <= 50'($signed(f2[i])) * 50'($signed(eye2[i]));
        u_r[i]  <= lav_pkg::round_sat(64'(cc[i]));
        // camera up stays within 2^17 in magnitude, 19 bits carry it
        pu_r[i] <= 51'($signed(u_r[i][18:0])) * 51'($signed(d2_e_r[i]));
      end
      d1_s_r <= n2_vec;
      d1_f_r <= f2;
      d1_e_r <= eye2;
      dot_s_r <= 52'(ps_r[0]) + 52'(ps_r[1]) + 52'(ps_r[2]);
      dot_f_r <= 52'(pf_r[0]) + 52'(pf_r[1]) + 52'(pf_r[2]);
      d2_s_r <= d1_s_r;
      d2_f_r <= d1_f_r;
      d2_e_r <= d1_e_r;
      shx_r  <= lav_pkg::round_sat(-(64'(dot_s_r)));
      shz_r  <= lav_pkg::round_sat(64'(dot_f_r));
      u3_r   <= u_r;
      d3_s_r <= d2_s_r;
      d3_f_r <= d2_f_r;
      dot_u_r <= 53'(pu_r[0]) + 53'(pu_r[1]) + 53'(pu_r[2]);
      u4_r   <= u3_r;
      shx4_r <= shx_r;
      shz4_r <= shz_r;
      d4_s_r <= d3_s_r;
      d4_f_r <= d3_f_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.side_x      <= 32'($signed(d4_s_r[0]));
      out_r.side_y      <= 32'($signed(d4_s_r[1]));
      out_r.side_z      <= 32'($signed(d4_s_r[2]));
      out_r.camera_up_x <= u4_r[0];
      out_r.camera_up_y <= u4_r[1];
      out_r.camera_up_z <= u4_r[2];
      out_r.back_x      <= -32'($signed(d4_f_r[0]));
      out_r.back_y      <= -32'($signed(d4_f_r[1]));
      out_r.back_z      <= -32'($signed(d4_f_r[2]));
      out_r.shift_x     <= shx4_r;
      out_r.shift_y     <= lav_pkg::round_sat(-(64'(dot_u_r)));
      out_r.shift_z     <= shz4_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r  <= 1'b0;
      c2_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      d3_vld_r  <= 1'b0;
      d4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      c1_vld_r  <= n1_vld;
      c2_vld_r  <= c1_vld_r;
      d1_vld_r  <= n2_vld;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
      d4_vld_r  <= d3_vld_r;
      out_vld_r <= d4_vld_r;
    end
  end

  assign out_word.valid = out_vld_r;
  assign out_word.data  = out_r;

  // helpers for the checks below
  logic side_ok, side_zero, up_zero, back_zero;
  always_comb begin
    side_ok = (out_r.side_x <= 32'sd65536) && (out_r.side_x >= -32'sd65536)
           && (out_r.side_y <= 32'sd65536) && (out_r.side_y >= -32'sd65536)
           && (out_r.side_z <= 32'sd65536) && (out_r.side_z >= -32'sd65536);
    side_zero = (out_r.side_x == '0) && (out_r.side_y == '0) && (out_r.side_z == '0);
    up_zero   = (out_r.camera_up_x == '0) && (out_r.camera_up_y == '0)
             && (out_r.camera_up_z == '0);
    back_zero = (out_r.back_x == '0) && (out_r.back_y == '0) && (out_r.back_z == '0);
  end

  `LAV_ASSERT_IMPL(a_side_unit, clk, rst_n, out_vld_r, side_ok)
  `LAV_ASSERT_IMPL(a_up_needs_side, clk, rst_n, out_vld_r && side_zero, up_zero)
  `LAV_ASSERT_IMPL(a_no_fwd, clk, rst_n, out_vld_r && back_zero, side_zero && out_r.shift_z == '0)

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// top level of the right-handed look-at view matrix block
// depends on lav_pkg, lav_chan_if, lav_front, lav_queue and lav_back
//
//   channel   dir  handshake      word
//   in_word   in   valid/ready    eye, target and up, nine q16.16 values
//   out_word  out  valid/ready    side, camera up, back rows and three shifts
//
// one word accepted per clock when the output is drained; each word passes
// through the two normalisers (32-step root and 17-step divide each).
// reset is synchronous and clears all valid state only.
// a stalled output freezes the back end; the four-entry queue and the front
// register keep taking words until they fill.
`default_nettype none

module look_at_view_matrix #(
  parameter int QUEUE_DEPTH = lav_pkg::QDEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lav_chan_if.sink   in_word,
  lav_chan_if.source out_word
);

  localparam int TW = $bits(lav_pkg::task_t);

  logic           q_push, q_full, q_pop, q_vld;
  lav_pkg::task_t q_data, q_head;

  lav_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  lav_queue #(.DEPTH(QUEUE_DEPTH), .W(TW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_vld)
  );

  lav_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
